### design/assert_macros.svh
// Assertion macros shared by the cipher RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/trrc_pkg.sv
// Package for the three-rotor reflector cipher: wiring tables, register
// indexes and mod-26 helper functions. Depends on nothing.
package trrc_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef t_letter t_map [0:25];

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_START   = 2'd2;

    localparam t_letter LAST_LETTER = 5'd25;

    localparam t_map WIRE_FAST = '{
        5'd11, 5'd10, 5'd9,  5'd7,  5'd6,  5'd5,  5'd3,  5'd18, 5'd0,
        5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14,
        5'd15, 5'd12, 5'd13, 5'd1,  5'd21, 5'd2,  5'd23, 5'd25};
    localparam t_map WIRE_MIDDLE = '{
        5'd12, 5'd13, 5'd1,  5'd21, 5'd2,  5'd23, 5'd25, 5'd0,  5'd18,
        5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd15, 5'd14,
        5'd8,  5'd20, 5'd24, 5'd19, 5'd17, 5'd4,  5'd22, 5'd16};
    localparam t_map WIRE_SLOW = '{
        5'd16, 5'd22, 5'd4,  5'd17, 5'd19, 5'd24, 5'd20, 5'd8,  5'd14,
        5'd15, 5'd0,  5'd18, 5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10,
        5'd11, 5'd25, 5'd23, 5'd2,  5'd21, 5'd1,  5'd13, 5'd12};
    localparam t_map INV_SLOW = '{
        5'd10, 5'd23, 5'd21, 5'd12, 5'd2,  5'd13, 5'd14, 5'd15, 5'd7,
        5'd16, 5'd17, 5'd18, 5'd25, 5'd24, 5'd8,  5'd9,  5'd0,  5'd3,
        5'd11, 5'd4,  5'd6,  5'd22, 5'd1,  5'd20, 5'd5,  5'd19};
    localparam t_map INV_MIDDLE = '{
        5'd7,  5'd2,  5'd4,  5'd9,  5'd23, 5'd10, 5'd11, 5'd12, 5'd18,
        5'd13, 5'd14, 5'd15, 5'd0,  5'd1,  5'd17, 5'd16, 5'd25, 5'd22,
        5'd8,  5'd21, 5'd19, 5'd3,  5'd24, 5'd5,  5'd20, 5'd6};
    localparam t_map INV_FAST = '{
        5'd8,  5'd21, 5'd23, 5'd6,  5'd11, 5'd5,  5'd4,  5'd3,  5'd16,
        5'd2,  5'd1,  5'd0,  5'd19, 5'd20, 5'd17, 5'd18, 5'd9,  5'd12,
        5'd7,  5'd13, 5'd15, 5'd22, 5'd10, 5'd24, 5'd14, 5'd25};
    localparam t_map REFLECT = '{
        5'd24, 5'd17, 5'd20, 5'd7,  5'd16, 5'd18, 5'd11, 5'd3,  5'd15,
        5'd23, 5'd13, 5'd6,  5'd14, 5'd10, 5'd12, 5'd8,  5'd4,  5'd1,
        5'd5,  5'd25, 5'd2,  5'd22, 5'd21, 5'd9,  5'd0,  5'd19};

    // Reduce any 5-bit code to 0..25 by one conditional subtract.
    function automatic t_letter fold26(input t_letter v);
        return (v > LAST_LETTER) ? 5'(v - 5'd26) : v;
    endfunction

    // (a + b) mod 26 for a, b in 0..25.
    function automatic t_letter add26(input t_letter a, input t_letter b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 6'd26) ? 5'(s - 6'd26) : s[LETTER_W-1:0];
    endfunction

    // (a - b) mod 26 for a, b in 0..25.
    function automatic t_letter sub26(input t_letter a, input t_letter b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + 6'd26 - {1'b0, b};
        return (a >= b) ? 5'(a - b) : s[LETTER_W-1:0];
    endfunction

    // Advance a 0..25 count by one with wrap.
    function automatic t_letter inc26(input t_letter v);
        return (v == LAST_LETTER) ? 5'd0 : 5'(v + 5'd1);
    endfunction

endpackage

### design/three_rotor_reflector_cipher.sv
// Top level of the three-rotor reflector cipher: rotor stepping, the
// letter path and the handshakes. Depends on trrc_pkg and assert_macros.svh.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------------
//  in       | sink      | i_in_valid / o_in_stall     | i_letter_in, i_start_of_message
//  out      | source    | o_out_valid / i_out_stall   | o_letter_out
//  cfg      | sink      | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while o_in_stall is low; a result passes
// first through the input register, loaded with the rotor step, and then through
// the result register, loaded from the table lookups forward, reflected and back.
// Reset is synchronous and active low; it zeroes the start rotations, the
// rotor positions, the step counts and both valid flags.
// A stall on the output holds the result register; the input register still
// drains into it when it is empty, so input stall rises only when both are full.
`include "assert_macros.svh"

module three_rotor_reflector_cipher (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  trrc_pkg::t_letter        i_letter_in,
    input  logic                     i_start_of_message,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output trrc_pkg::t_letter        o_letter_out,
    input  logic                     i_cfg_we,
    input  logic [trrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  trrc_pkg::t_letter        i_cfg_data
);
    import trrc_pkg::*;

    // Configuration registers.
    t_letter r_fast_start, r_mid_start, r_slow_start;

    // Rotor state, always kept in 0..25.
    t_letter r_fast_pos, r_mid_pos, r_slow_pos;
    t_letter r_fast_cnt, r_mid_cnt;

    // Input register: the folded letter and the rotor positions it sees.
    logic    r_a_valid;
    t_letter r_a_letter, r_a_fast, r_a_mid, r_a_slow;

    // Result register.
    logic    r_out_valid;
    t_letter r_out_letter;

    logic    in_accept, out_free, a_free;
    t_letter use_fast, use_mid, use_slow, use_fcnt, use_mcnt;
    t_letter n_fast_pos, n_mid_pos, n_slow_pos, n_fast_cnt, n_mid_cnt;
    t_letter f1, f2, f3, rf, b1, b2, n_letter;

    // The result register can load when it is empty or being emptied; the
    // input register can load when it is empty or moving forward.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_free     = !r_a_valid || out_free;
    assign o_in_stall = !a_free;
    assign in_accept  = i_in_valid && a_free;

    assign o_out_valid  = r_out_valid;
    assign o_letter_out = r_out_letter;

    // Start of message reloads the rotors and clears the step counts before
    // this letter is enciphered.
    always_comb begin
        use_fast = i_start_of_message ? fold26(r_fast_start) : r_fast_pos;
        use_mid  = i_start_of_message ? fold26(r_mid_start)  : r_mid_pos;
        use_slow = i_start_of_message ? fold26(r_slow_start) : r_slow_pos;
        use_fcnt = i_start_of_message ? 5'd0 : r_fast_cnt;
        use_mcnt = i_start_of_message ? 5'd0 : r_mid_cnt;
    end

    // Stepping after the letter: the fast rotor always moves, the middle one
    // when the letter count wraps, the slow one when the middle count wraps.
    always_comb begin
        n_fast_pos = inc26(use_fast);
        n_fast_cnt = inc26(use_fcnt);
        n_mid_pos  = use_mid;
        n_mid_cnt  = use_mcnt;
        n_slow_pos = use_slow;
        if (use_fcnt == LAST_LETTER) begin
            n_mid_pos = inc26(use_mid);
            n_mid_cnt = inc26(use_mcnt);
            if (use_mcnt == LAST_LETTER) begin
                n_slow_pos = inc26(use_slow);
            end
        end
    end

    // Letter path: forward through the rotors, reflect, then back.
    always_comb begin
        f1       = WIRE_FAST[sub26(r_a_letter, r_a_fast)];
        f2       = WIRE_MIDDLE[sub26(f1, r_a_mid)];
        f3       = WIRE_SLOW[sub26(f2, r_a_slow)];
        rf       = REFLECT[f3];
        b1       = add26(INV_SLOW[rf], r_a_slow);
        b2       = add26(INV_MIDDLE[b1], r_a_mid);
        n_letter = add26(INV_FAST[b2], r_a_fast);
    end

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_start <= '0;
            r_mid_start  <= '0;
            r_slow_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FAST_START:   r_fast_start <= i_cfg_data;
                CFG_MIDDLE_START: r_mid_start  <= i_cfg_data;
                CFG_SLOW_START:   r_slow_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rotor state moves once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_pos <= '0;
            r_mid_pos  <= '0;
            r_slow_pos <= '0;
            r_fast_cnt <= '0;
            r_mid_cnt  <= '0;
        end else if (in_accept) begin
            r_fast_pos <= n_fast_pos;
            r_mid_pos  <= n_mid_pos;
            r_slow_pos <= n_slow_pos;
            r_fast_cnt <= n_fast_cnt;
            r_mid_cnt  <= n_mid_cnt;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (out_free) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_letter <= fold26(i_letter_in);
            r_a_fast   <= use_fast;
            r_a_mid    <= use_mid;
            r_a_slow   <= use_slow;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_a_valid) begin
            r_out_letter <= n_letter;
        end
    end

    // Checks on the stepping and the pipeline.
    `ASSERT_CLK(a_state_range,
        (r_fast_pos <= LAST_LETTER) && (r_mid_pos <= LAST_LETTER) &&
        (r_slow_pos <= LAST_LETTER) && (r_fast_cnt <= LAST_LETTER) &&
        (r_mid_cnt <= LAST_LETTER),
        "rotor state left the range 0..25")
    `ASSERT_NEXT(a_stage_moves, r_a_valid && out_free, o_out_valid,
        "a transaction in the input register did not reach the output")
    `ASSERT_NEXT(a_fast_steps, in_accept && !i_start_of_message,
        r_fast_pos == inc26($past(r_fast_pos)),
        "fast rotor did not advance by one")
    `ASSERT_NEXT(a_mid_holds,
        in_accept && !i_start_of_message && (r_fast_cnt != LAST_LETTER),
        $stable(r_mid_pos) && $stable(r_slow_pos),
        "middle or slow rotor moved without a count wrap")

endmodule

### dv/rotor_cipher_checker.sv
// Checker for the three-rotor reflector cipher: mirrors rotor stepping and the
// letter path, and compares every output transaction with its prediction.
// Depends on trrc_pkg for the letter type and the register indexes.
`timescale 1ns / 1ps

module rotor_cipher_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  trrc_pkg::t_letter              i_letter_in,
    input  logic                           i_start_of_message,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  trrc_pkg::t_letter              i_letter_out,
    input  logic                           i_cfg_we,
    input  logic [trrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  trrc_pkg::t_letter              i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_slow_steps
);
    import trrc_pkg::*;

    localparam int ALPHABET = 26;

    int fast_wiring [26] = '{11, 10, 9, 7, 6, 5, 3, 18, 0, 16, 22, 4, 17,
                             19, 24, 20, 8, 14, 15, 12, 13, 1, 21, 2, 23, 25};
    int middle_wiring [26] = '{12, 13, 1, 21, 2, 23, 25, 0, 18, 3, 5, 6, 7,
                               9, 10, 11, 15, 14, 8, 20, 24, 19, 17, 4, 22, 16};
    int slow_wiring [26] = '{16, 22, 4, 17, 19, 24, 20, 8, 14, 15, 0, 18, 3,
                             5, 6, 7, 9, 10, 11, 25, 23, 2, 21, 1, 13, 12};
    int reflector [26] = '{24, 17, 20, 7, 16, 18, 11, 3, 15, 23, 13, 6, 14,
                           10, 12, 8, 4, 1, 5, 25, 2, 22, 21, 9, 0, 19};
    int fast_unwiring [26];
    int middle_unwiring [26];
    int slow_unwiring [26];

    int fast_start, middle_start, slow_start;
    int fast_rot, middle_rot, slow_rot;
    int letter_count, middle_count;
    t_letter expected_letters [$];
    t_letter want;

    // The return path uses the inverse of each rotor's wiring.
    initial begin
        for (int i = 0; i < ALPHABET; i++) begin
            fast_unwiring[fast_wiring[i]] = i;
            middle_unwiring[middle_wiring[i]] = i;
            slow_unwiring[slow_wiring[i]] = i;
        end
    end

    function automatic int wrap_code(input int v);
        return (v >= ALPHABET) ? v - ALPHABET : v;
    endfunction

    function automatic t_letter encipher_letter(input int x, input int fp, input int mp,
                                                input int sp);
        int v;
        v = fast_wiring[(x + ALPHABET - fp) % ALPHABET];
        v = middle_wiring[(v + ALPHABET - mp) % ALPHABET];
        v = slow_wiring[(v + ALPHABET - sp) % ALPHABET];
        v = reflector[v];
        v = (slow_unwiring[v] + sp) % ALPHABET;
        v = (middle_unwiring[v] + mp) % ALPHABET;
        v = (fast_unwiring[v] + fp) % ALPHABET;
        return t_letter'(v);
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("MISMATCH at %0t ns: %s, expected %0d, got %0d", $time, what, exp_val,
                 got_val);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fast_start = 0;
            middle_start = 0;
            slow_start = 0;
            fast_rot = 0;
            middle_rot = 0;
            slow_rot = 0;
            letter_count = 0;
            middle_count = 0;
            expected_letters.delete();
            o_errors = 0;
            o_checked = 0;
            o_slow_steps = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FAST_START:   fast_start = i_cfg_data;
                    CFG_MIDDLE_START: middle_start = i_cfg_data;
                    CFG_SLOW_START:   slow_start = i_cfg_data;
                    default: ;
                endcase
            end
            // Results leave before the new letter is queued; a letter accepted
            // at this edge cannot already have its result on the output.
            if (i_out_valid && !i_out_stall) begin
                if (expected_letters.size() == 0) begin
                    report_mismatch("result with nothing expected", -1, i_letter_out);
                end else begin
                    want = expected_letters.pop_front();
                    if (want != i_letter_out)
                        report_mismatch("letter_out", want, i_letter_out);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_start_of_message) begin
                    fast_rot = wrap_code(fast_start);
                    middle_rot = wrap_code(middle_start);
                    slow_rot = wrap_code(slow_start);
                    letter_count = 0;
                    middle_count = 0;
                end
                expected_letters.push_back(encipher_letter(wrap_code(i_letter_in),
                                                           fast_rot, middle_rot, slow_rot));
                fast_rot = (fast_rot + 1) % ALPHABET;
                letter_count = (letter_count + 1) % ALPHABET;
                if (letter_count == 0) begin
                    middle_rot = (middle_rot + 1) % ALPHABET;
                    middle_count = (middle_count + 1) % ALPHABET;
                    if (middle_count == 0) begin
                        slow_rot = (slow_rot + 1) % ALPHABET;
                        o_slow_steps++;
                    end
                end
            end
        end
        o_pending = expected_letters.size();
    end

endmodule

### dv/tb_three_rotor_reflector_cipher.sv
// Top of the cipher testbench: clock, reset, stimulus, back-pressure and the
// verdict. Depends on trrc_pkg, the cipher RTL and rotor_cipher_checker.
`timescale 1ns / 1ps

module tb_three_rotor_reflector_cipher;
    import trrc_pkg::*;

    // Index 3 names no register; writes to it must leave the rotors alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    // Cycles without any transaction before the run is declared hung. The longest
    // honest quiet stretch is a random gap or stall, or a drain plus settle.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 125;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_letter              i_letter_in = '0;
    logic                 i_start_of_message = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_letter              o_letter_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FAST_START;
    t_letter              i_cfg_data = '0;

    int error_count, pending_letters, checked_letters, slow_steps;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int letters_sent = 0;
    int messages_started = 0;
    int idle_cycles;

    three_rotor_reflector_cipher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_letter_in        (i_letter_in),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_letter_out       (o_letter_out),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    rotor_cipher_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_letter_in        (i_letter_in),
        .i_start_of_message (i_start_of_message),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_letter_out       (o_letter_out),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_errors           (error_count),
        .o_pending          (pending_letters),
        .o_checked          (checked_letters),
        .o_slow_steps       (slow_steps)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The receiver stalls at random, at the rate the current phase sets. One
    // assignment per edge, so a stall never glitches within a time step.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Any accepted transaction on any channel restarts the count; a long quiet
    // stretch means the block has hung.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Mostly in-range letters, with a tenth of codes 26..31 that the block
    // folds back onto 0..5.
    function automatic t_letter random_letter();
        if ($urandom_range(0, 9) == 0)
            return t_letter'($urandom_range(26, 31));
        return t_letter'($urandom_range(0, 25));
    endfunction

    // Start rotations lean toward the wrap points and the out-of-range codes.
    function automatic t_letter random_rotation();
        case ($urandom_range(0, 5))
            0: return t_letter'(0);
            1: return LAST_LETTER;
            2: return t_letter'($urandom_range(26, 31));
            default: return t_letter'($urandom_range(0, 25));
        endcase
    endfunction

    // Offers one letter and returns at the edge that accepts it. Valid stays
    // high afterwards, so back-to-back letters need no second assignment in
    // the same step. Stall is sampled at the falling edge, where it already
    // holds the value the next rising edge will see.
    task automatic send_letter(input t_letter letter, input logic start_flag);
        logic taken;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_letter_in <= letter;
        i_start_of_message <= start_flag;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        letters_sent++;
        if (start_flag)
            messages_started++;
    endtask

    // Holds the sender off until every predicted letter has come back, then
    // lets the pipeline settle so that the block is truly idle. It waits for a
    // clock edge first so that the checker has queued the last accepted letter.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_letters == 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the three start rotations on consecutive edges, optionally
    // followed by a write to the unused index. Call only while idle.
    task automatic write_rotations(input t_letter fast, input t_letter middle,
                                   input t_letter slow, input logic hit_spare);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FAST_START;
        i_cfg_data <= fast;
        @(posedge i_clk);
        i_cfg_index <= CFG_MIDDLE_START;
        i_cfg_data <= middle;
        @(posedge i_clk);
        i_cfg_index <= CFG_SLOW_START;
        i_cfg_data <= slow;
        @(posedge i_clk);
        if (hit_spare) begin
            i_cfg_index <= CFG_SPARE_INDEX;
            i_cfg_data <= t_letter'($urandom_range(0, 31));
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A message normally opens with the start flag. Broken ones either skip
    // it, so the rotors carry on from the previous message, or raise it again
    // part-way through.
    task automatic send_message(input int length);
        logic open_flag;
        open_flag = ($urandom_range(0, 5) != 0);
        for (int k = 0; k < length; k++) begin
            if (k == 0)
                send_letter(random_letter(), open_flag);
            else
                send_letter(random_letter(), ($urandom_range(0, 39) == 0));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no start flag yet, so the rotors run from rotation 0 with
        // registers at reset; the letter extremes and out-of-range codes.
        send_letter(t_letter'(0), 1'b0);
        send_letter(LAST_LETTER, 1'b0);
        send_letter(t_letter'(26), 1'b0);
        send_letter(t_letter'(31), 1'b0);
        drain_results();

        // All rotors start at 25, so the first step wraps the fast rotor.
        write_rotations(LAST_LETTER, LAST_LETTER, LAST_LETTER, 1'b1);
        send_letter(t_letter'(0), 1'b1);
        send_letter(LAST_LETTER, 1'b0);
        send_letter(t_letter'(13), 1'b0);
        send_letter(t_letter'(31), 1'b0);
        drain_results();

        // Start rotations outside 0..25 are folded when loaded.
        write_rotations(t_letter'(26), t_letter'(31), t_letter'(30), 1'b0);
        send_letter(t_letter'(5), 1'b1);
        send_letter(t_letter'(7), 1'b0);
        send_letter(t_letter'(30), 1'b0);
        send_letter(t_letter'(0), 1'b1);
        drain_results();

        // Back to all zero; a fresh start restores the reset behavior.
        write_rotations(t_letter'(0), t_letter'(0), t_letter'(0), 1'b0);
        send_letter(t_letter'(0), 1'b1);
        send_letter(LAST_LETTER, 1'b0);
        send_letter(t_letter'(1), 1'b1);
        send_letter(t_letter'(27), 1'b0);
        drain_results();

        // Random phases, one per idling mix. Each starts from idle with fresh
        // start rotations.
        for (int phase = 0; phase < 4; phase++) begin
            int phase_start;
            bit mid_drained;
            drain_results();
            mid_drained = 1'b0;
            write_rotations(random_rotation(), random_rotation(), random_rotation(),
                            ($urandom_range(0, 1) == 1));
            case (phase)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 72; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 72; end
                default: begin in_idle_pct = 8; out_stall_pct = 8; end
            endcase
            phase_start = letters_sent;
            while (letters_sent - phase_start < PHASE_ITEMS) begin
                // Halfway through the stalling phase the sender waits once
                // for every outstanding result.
                if (phase == 2 && !mid_drained &&
                    letters_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain_results();
                    mid_drained = 1'b1;
                end
                if ($urandom_range(0, 7) == 0)
                    send_message($urandom_range(27, 120));
                else
                    send_message($urandom_range(1, 40));
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_letters == 0);
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d letters in %0d flagged messages under four idling mixes,",
                 letters_sent, messages_started);
        $display("Summary: %0d results checked, slow rotor stepped %0d times",
                 checked_letters, slow_steps);
        if (error_count == 0 && pending_letters == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
